### src/wpm_pkg.sv
// Shared types, constants and helpers for the weighted phrase matcher.
// Depends on nothing; used by wpm_div and weighted_phrase_matcher.
package wpm_pkg;

   localparam int MAX_NODES      = 1024;
   localparam int NODE_W         = $clog2(MAX_NODES);
   localparam int CNT_W          = NODE_W + 1;
   localparam int TOK_W          = 12;
   localparam int Q_W            = 24;
   localparam int PLEN_W         = 6;
   localparam int MAX_PHRASE_LEN = 32;
   localparam int SUM_W          = Q_W + 2;

   localparam logic [Q_W-1:0] DEFAULT_SCORE_RST = Q_W'(6144);

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_BUILD = 2'd1,
      KIND_STEP  = 2'd2,
      KIND_FINAL = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SC_ADD,
      SC_STEP,
      SC_DESC
   } scan_ctx_type;

   typedef enum logic {
      DC_STEP,
      DC_BUILD
   } desc_ctx_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_ADD_RD, S_ADD_LD, S_SCAN_RD, S_SCAN_CK, S_ADD_UPD, S_ADD_NEW,
      S_DESC_RD, S_DESC_LD, S_STEP_RD, S_STEP_LD, S_FIN_RD, S_FIN_LD,
      S_B_INIT, S_B_POP, S_B_POPLD, S_B_URD, S_B_ULD, S_B_CRD, S_B_CCK,
      S_B_ORD, S_B_OLD, S_B_WR, S_DONE
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] fail;
      logic              is_end;
      logic [Q_W-1:0]    outs;
      logic [Q_W-1:0]    path;
      logic [Q_W-1:0]    tscore;
      logic [NODE_W-1:0] parent;
      logic [TOK_W-1:0]  token;
   } node_rec_type;

   function automatic logic signed [SUM_W-1:0] ext_q(input logic [Q_W-1:0] v);
      return {{(SUM_W-Q_W){v[Q_W-1]}}, v};
   endfunction

   function automatic logic [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((1 << (Q_W - 1)) - 1);
      lo = -SUM_W'(1 << (Q_W - 1));
      if (v > hi) return hi[Q_W-1:0];
      if (v < lo) return lo[Q_W-1:0];
      return v[Q_W-1:0];
   endfunction

endpackage

### src/wpm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module wpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### src/wpm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// Depends on wpm_pkg.
module wpm_div
   import wpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [Q_W-1:0]    dividend,
   input  logic [PLEN_W-1:0] divisor,
   output logic              done,
   output logic [Q_W-1:0]    quotient
);

   localparam int STEP_W = $clog2(Q_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [Q_W-1:0]    acc_ff, acc_in;
   logic [PLEN_W-1:0] rem_ff, rem_in;
   logic [PLEN_W-1:0] div_ff, div_in;
   logic [PLEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, acc_ff[Q_W-1]};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[Q_W-1];
         acc_in  = dividend[Q_W-1] ? Q_W'(0) - dividend : dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = PLEN_W'(trial - {1'b0, div_ff});
            acc_in = {acc_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[PLEN_W-1:0];
            acc_in = {acc_ff[Q_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? Q_W'(0) - acc_ff : acc_ff;

endmodule

### src/weighted_phrase_matcher.sv
// Top level of the weighted phrase matcher: control sequencer over the node table.
// Depends on wpm_pkg, wpm_ram and wpm_div.
//
// Usage: one request beat on req_* gives exactly one response beat on rsp_*.
// req_tuser carries the kind: add a phrase token, build links, step, finalize.
// Add (0..1023 entries scanned, plus a division when the phrase score is nonzero)
// walks the node table one entry at a time looking for an existing child.
// Step scans children of the state, then of each failure-link node in turn.
// Build runs breadth-first over the whole table: per queued node a full
// table sweep, and per child of a non-root node a failure-link descent.
// Node table and BFS queue are synchronous RAMs with a registered read;
// the root record is not stored and reads as all zero, so reset needs
// no clearing pass.
// Reset leaves the root alone in the table, add cursor at the root and the
// default token score at 1.5. csr_* writes the default score any time.
// The response sits in an output register; req_tready rises again as soon
// as the sequencer is idle, even while rsp_tvalid waits on a stalled
// receiver. A finished item holds in its last state until that slot frees.
module weighted_phrase_matcher
   import wpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // token[11:0], phrase_score[35:12], phrase_length[41:36], state_id[51:42]
   input  logic [55:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // score[23:0], next_state[33:24], status[34]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);

   // request fields
   logic [TOK_W-1:0]  req_token;
   logic [Q_W-1:0]    req_pscore;
   logic [PLEN_W-1:0] req_plen;
   logic [NODE_W-1:0] req_state;
   logic [PLEN_W-1:0] plen_clamp;
   logic              req_fire, rsp_free;

   assign req_token  = req_tdata[11:0];
   assign req_pscore = req_tdata[35:12];
   assign req_plen   = req_tdata[41:36];
   assign req_state  = req_tdata[51:42];
   assign csr_ready  = 1'b1;

   // clamp the phrase length to 1..MAX_PHRASE_LEN
   always_comb begin
      plen_clamp = req_plen;
      if (req_plen == '0) plen_clamp = PLEN_W'(1);
      if (req_plen > PLEN_W'(MAX_PHRASE_LEN)) plen_clamp = PLEN_W'(MAX_PHRASE_LEN);
   end

   state_type         st_ff, st_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic              skip_ff, skip_in;
   logic [Q_W-1:0]    dflt_ff;
   logic [TOK_W-1:0]  tok_ff, tok_in;
   logic              last_ff, last_in;
   logic [NODE_W-1:0] s_ff, s_in;
   logic [Q_W-1:0]    ts_ff, ts_in;
   logic [Q_W-1:0]    ppath_ff, ppath_in;
   logic [NODE_W-1:0] f_ff, f_in;
   logic [CNT_W-1:0]  scan_i_ff, scan_i_in;
   logic [NODE_W-1:0] scan_p_ff, scan_p_in;
   logic [TOK_W-1:0]  scan_t_ff, scan_t_in;
   scan_ctx_type      scan_ctx_ff, scan_ctx_in;
   desc_ctx_type      desc_ctx_ff, desc_ctx_in;
   node_rec_type      hrec_ff, hrec_in;
   logic [NODE_W-1:0] hidx_ff, hidx_in;
   logic [NODE_W-1:0] u_ff, u_in;
   logic [NODE_W-1:0] uf_ff, uf_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  bc_ff, bc_in;
   node_rec_type      brec_ff, brec_in;
   logic [NODE_W-1:0] bf_ff, bf_in;
   logic [NODE_W-1:0] o_ff, o_in;
   logic [Q_W-1:0]    bout_ff, bout_in;
   logic [Q_W-1:0]    res_score_ff, res_score_in;
   logic [NODE_W-1:0] res_next_ff, res_next_in;
   logic              res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]    rsp_score_ff, rsp_score_in;
   logic [NODE_W-1:0] rsp_next_ff, rsp_next_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rd_root_ff;

   assign req_tready = (st_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // node table and queue ports
   logic              ram_we;
   logic [NODE_W-1:0] ram_wa, ram_ra;
   node_rec_type      ram_wd, ram_rd, node_rd;
   logic              q_we;
   logic [NODE_W-1:0] q_wa, q_wd, q_ra, q_rd;

   logic              div_start, div_done;
   logic [Q_W-1:0]    div_quo;

   wpm_ram #(.WIDTH($bits(node_rec_type)), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   wpm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wa),
      .wr_data (q_wd),
      .rd_addr (q_ra),
      .rd_data (q_rd)
   );

   wpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_pscore),
      .divisor  (plen_clamp),
      .done     (div_done),
      .quotient (div_quo)
   );

   // the root is never stored: it reads as all zero
   assign node_rd = rd_root_ff ? '0 : ram_rd;

   logic scan_end, scan_hit;
   assign scan_end = (scan_i_ff >= cnt_ff);
   assign scan_hit = (node_rd.parent == scan_p_ff) && (node_rd.token == scan_t_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (kind_type'(req_tuser))
                  KIND_ADD: begin
                     if (skip_ff) st_in = S_DONE;
                     else if (req_pscore == '0) st_in = S_ADD_RD;
                     else st_in = S_DIV;
                  end
                  KIND_BUILD: st_in = S_B_INIT;
                  KIND_STEP:  st_in = S_STEP_RD;
                  default:    st_in = S_FIN_RD;
               endcase
            end
         end
         S_DIV:     if (div_done) st_in = S_ADD_RD;
         S_ADD_RD:  st_in = S_ADD_LD;
         S_ADD_LD:  st_in = S_SCAN_RD;
         S_SCAN_RD: begin
            if (scan_end) begin
               case (scan_ctx_ff)
                  SC_ADD:  st_in = S_ADD_NEW;
                  SC_STEP: st_in = S_SCAN_RD;
                  default: begin
                     if (f_ff != '0) st_in = S_DESC_RD;
                     else if (desc_ctx_ff == DC_STEP) st_in = S_DONE;
                     else st_in = S_B_ORD;
                  end
               endcase
            end else begin
               st_in = S_SCAN_CK;
            end
         end
         S_SCAN_CK: begin
            if (scan_hit) begin
               case (scan_ctx_ff)
                  SC_ADD:  st_in = S_ADD_UPD;
                  SC_STEP: st_in = S_DONE;
                  default: st_in = (desc_ctx_ff == DC_STEP) ? S_DONE : S_B_ORD;
               endcase
            end else begin
               st_in = S_SCAN_RD;
            end
         end
         S_ADD_UPD, S_ADD_NEW, S_FIN_LD: st_in = S_DONE;
         S_DESC_RD: st_in = S_DESC_LD;
         S_DESC_LD: st_in = S_SCAN_RD;
         S_STEP_RD: st_in = S_STEP_LD;
         S_STEP_LD: st_in = S_SCAN_RD;
         S_FIN_RD:  st_in = S_FIN_LD;
         S_B_INIT:  st_in = S_B_POP;
         S_B_POP:   st_in = (head_ff >= tail_ff) ? S_DONE : S_B_POPLD;
         S_B_POPLD: st_in = S_B_URD;
         S_B_URD:   st_in = S_B_ULD;
         S_B_ULD:   st_in = S_B_CRD;
         S_B_CRD:   st_in = (bc_ff >= cnt_ff) ? S_B_POP : S_B_CCK;
         S_B_CCK: begin
            if (node_rd.parent != u_ff) st_in = S_B_CRD;
            else if (u_ff == '0) st_in = S_B_ORD;
            else st_in = S_SCAN_RD;
         end
         S_B_ORD:   st_in = S_B_OLD;
         S_B_OLD: begin
            if (node_rd.is_end || node_rd.fail == '0) st_in = S_B_WR;
            else st_in = S_B_ORD;
         end
         S_B_WR:    st_in = S_B_CRD;
         S_DONE:    if (rsp_free) st_in = S_IDLE;
         default:   st_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [Q_W-1:0] new_ts, new_path;
      logic           new_end;
      node_rec_type   wrec;

      cnt_in        = cnt_ff;
      cursor_in     = cursor_ff;
      skip_in       = skip_ff;
      tok_in        = tok_ff;
      last_in       = last_ff;
      s_in          = s_ff;
      ts_in         = ts_ff;
      ppath_in      = ppath_ff;
      f_in          = f_ff;
      scan_i_in     = scan_i_ff;
      scan_p_in     = scan_p_ff;
      scan_t_in     = scan_t_ff;
      scan_ctx_in   = scan_ctx_ff;
      desc_ctx_in   = desc_ctx_ff;
      hrec_in       = hrec_ff;
      hidx_in       = hidx_ff;
      u_in          = u_ff;
      uf_in         = uf_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      bc_in         = bc_ff;
      brec_in       = brec_ff;
      bf_in         = bf_ff;
      o_in          = o_ff;
      bout_in       = bout_ff;
      res_score_in  = res_score_ff;
      res_next_in   = res_next_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_score_in  = rsp_score_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_wa        = '0;
      ram_wd        = '0;
      ram_ra        = '0;
      q_we          = 1'b0;
      q_wa          = '0;
      q_wd          = '0;
      q_ra          = '0;
      div_start     = 1'b0;
      new_ts        = '0;
      new_path      = '0;
      new_end       = 1'b0;
      wrec          = '0;

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               tok_in        = req_token;
               last_in       = req_tlast;
               s_in          = ({1'b0, req_state} >= cnt_ff) ? '0 : req_state;
               res_score_in  = '0;
               res_next_in   = '0;
               res_status_in = 1'b0;
               if (kind_type'(req_tuser) == KIND_ADD) begin
                  if (skip_ff) begin
                     // drop the rest of a phrase that hit a full table
                     res_status_in = 1'b1;
                     if (req_tlast) skip_in = 1'b0;
                  end else if (req_pscore == '0) begin
                     ts_in = dflt_ff;
                  end else begin
                     div_start = 1'b1;
                  end
               end
            end
         end
         S_DIV: if (div_done) ts_in = div_quo;
         S_ADD_RD: ram_ra = cursor_ff;
         S_ADD_LD: begin
            ppath_in    = node_rd.path;
            scan_p_in   = cursor_ff;
            scan_t_in   = tok_ff;
            scan_i_in   = CNT_W'(1);
            scan_ctx_in = SC_ADD;
         end
         S_SCAN_RD: begin
            if (scan_end) begin
               case (scan_ctx_ff)
                  SC_STEP: begin
                     // no direct child: descend from the failure link
                     scan_p_in   = f_ff;
                     scan_i_in   = CNT_W'(1);
                     scan_ctx_in = SC_DESC;
                  end
                  SC_DESC: begin
                     if (f_ff == '0) begin
                        // a build descent leaves the response untouched
                        if (desc_ctx_ff == DC_STEP) begin
                           res_score_in = sat_q(-ext_q(ppath_ff));
                           res_next_in  = '0;
                        end
                        bf_in        = '0;
                        o_in         = '0;
                     end
                  end
                  default: ;
               endcase
            end else begin
               ram_ra = scan_i_ff[NODE_W-1:0];
            end
         end
         S_SCAN_CK: begin
            if (scan_hit) begin
               hrec_in = node_rd;
               hidx_in = scan_i_ff[NODE_W-1:0];
               case (scan_ctx_ff)
                  SC_STEP: begin
                     res_score_in = sat_q(ext_q(node_rd.tscore) + ext_q(node_rd.outs));
                     res_next_in  = scan_i_ff[NODE_W-1:0];
                  end
                  SC_DESC: begin
                     if (desc_ctx_ff == DC_STEP) begin
                        res_score_in = sat_q(ext_q(node_rd.path) - ext_q(ppath_ff)
                                             + ext_q(node_rd.outs));
                        res_next_in  = scan_i_ff[NODE_W-1:0];
                     end
                     bf_in        = scan_i_ff[NODE_W-1:0];
                     o_in         = scan_i_ff[NODE_W-1:0];
                  end
                  default: ;
               endcase
            end else begin
               scan_i_in = scan_i_ff + CNT_W'(1);
            end
         end
         S_ADD_UPD: begin
            // existing prefix: keep the larger token score, refresh path
            new_end  = hrec_ff.is_end | last_ff;
            new_ts   = ($signed(ts_ff) > $signed(hrec_ff.tscore)) ? ts_ff : hrec_ff.tscore;
            new_path = sat_q(ext_q(ppath_ff) + ext_q(new_ts));
            wrec        = hrec_ff;
            wrec.is_end = new_end;
            wrec.tscore = new_ts;
            wrec.path   = new_path;
            wrec.outs   = new_end ? new_path : '0;
            ram_we      = 1'b1;
            ram_wa      = hidx_ff;
            ram_wd      = wrec;
            res_next_in = hidx_ff;
            cursor_in   = last_ff ? '0 : hidx_ff;
         end
         S_ADD_NEW: begin
            if (cnt_ff >= CNT_W'(MAX_NODES)) begin
               res_status_in = 1'b1;
               cursor_in     = '0;
               skip_in       = ~last_ff;
            end else begin
               new_path    = sat_q(ext_q(ppath_ff) + ext_q(ts_ff));
               wrec.token  = tok_ff;
               wrec.parent = cursor_ff;
               wrec.tscore = ts_ff;
               wrec.path   = new_path;
               wrec.is_end = last_ff;
               wrec.outs   = last_ff ? new_path : '0;
               wrec.fail   = '0;
               ram_we      = 1'b1;
               ram_wa      = cnt_ff[NODE_W-1:0];
               ram_wd      = wrec;
               cnt_in      = cnt_ff + CNT_W'(1);
               res_next_in = cnt_ff[NODE_W-1:0];
               cursor_in   = last_ff ? '0 : cnt_ff[NODE_W-1:0];
            end
         end
         S_DESC_RD: ram_ra = f_ff;
         S_DESC_LD: begin
            f_in        = node_rd.fail;
            scan_p_in   = node_rd.fail;
            scan_i_in   = CNT_W'(1);
            scan_ctx_in = SC_DESC;
         end
         S_STEP_RD: ram_ra = s_ff;
         S_STEP_LD: begin
            ppath_in    = node_rd.path;
            f_in        = node_rd.fail;
            scan_p_in   = s_ff;
            scan_t_in   = tok_ff;
            scan_i_in   = CNT_W'(1);
            scan_ctx_in = SC_STEP;
            desc_ctx_in = DC_STEP;
         end
         S_FIN_RD: ram_ra = s_ff;
         S_FIN_LD: res_score_in = sat_q(-ext_q(node_rd.path));
         S_B_INIT: begin
            q_we    = 1'b1;
            q_wa    = '0;
            q_wd    = '0;
            head_in = '0;
            tail_in = CNT_W'(1);
         end
         S_B_POP: begin
            if (head_ff >= tail_ff) begin
               cursor_in = '0;
               skip_in   = 1'b0;
            end else begin
               q_ra    = head_ff[NODE_W-1:0];
               head_in = head_ff + CNT_W'(1);
            end
         end
         S_B_POPLD: u_in = q_rd;
         S_B_URD:   ram_ra = u_ff;
         S_B_ULD: begin
            uf_in = node_rd.fail;
            bc_in = CNT_W'(1);
         end
         S_B_CRD: if (bc_ff < cnt_ff) ram_ra = bc_ff[NODE_W-1:0];
         S_B_CCK: begin
            if (node_rd.parent != u_ff) begin
               bc_in = bc_ff + CNT_W'(1);
            end else begin
               brec_in = node_rd;
               if (u_ff == '0) begin
                  bf_in = '0;
                  o_in  = '0;
               end else begin
                  f_in        = uf_ff;
                  scan_p_in   = uf_ff;
                  scan_t_in   = node_rd.token;
                  scan_i_in   = CNT_W'(1);
                  scan_ctx_in = SC_DESC;
                  desc_ctx_in = DC_BUILD;
               end
            end
         end
         S_B_ORD: ram_ra = o_ff;
         S_B_OLD: begin
            // walk failure links to the nearest phrase end
            if (node_rd.is_end) begin
               bout_in = node_rd.outs;
            end else begin
               bout_in = '0;
               o_in    = node_rd.fail;
            end
         end
         S_B_WR: begin
            wrec      = brec_ff;
            wrec.fail = bf_ff;
            wrec.outs = sat_q(ext_q(brec_ff.is_end ? brec_ff.path : '0) + ext_q(bout_ff));
            ram_we    = 1'b1;
            ram_wa    = bc_ff[NODE_W-1:0];
            ram_wd    = wrec;
            if (tail_ff < CNT_W'(MAX_NODES)) begin
               q_we    = 1'b1;
               q_wa    = tail_ff[NODE_W-1:0];
               q_wd    = bc_ff[NODE_W-1:0];
               tail_in = tail_ff + CNT_W'(1);
            end
            bc_in = bc_ff + CNT_W'(1);
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_score_in  = res_score_ff;
               rsp_next_in   = res_next_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         cnt_ff       <= CNT_W'(1);
         cursor_ff    <= '0;
         skip_ff      <= 1'b0;
         dflt_ff      <= DEFAULT_SCORE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) dflt_ff <= csr_data;
      end
      rd_root_ff    <= (ram_ra == '0);
      tok_ff        <= tok_in;
      last_ff       <= last_in;
      s_ff          <= s_in;
      ts_ff         <= ts_in;
      ppath_ff      <= ppath_in;
      f_ff          <= f_in;
      scan_i_ff     <= scan_i_in;
      scan_p_ff     <= scan_p_in;
      scan_t_ff     <= scan_t_in;
      scan_ctx_ff   <= scan_ctx_in;
      desc_ctx_ff   <= desc_ctx_in;
      hrec_ff       <= hrec_in;
      hidx_ff       <= hidx_in;
      u_ff          <= u_in;
      uf_ff         <= uf_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      bc_ff         <= bc_in;
      brec_ff       <= brec_in;
      bf_ff         <= bf_in;
      o_ff          <= o_in;
      bout_ff       <= bout_in;
      res_score_ff  <= res_score_in;
      res_next_ff   <= res_next_in;
      res_status_ff <= res_status_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_next_ff, rsp_score_ff};

endmodule
